>>> hdl/lkv_pkg.sv
package lkv_pkg;

    localparam int CAPACITY = 8;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RANK_W   = IDX_W;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CFG_W    = 4;
    localparam int WORD_W   = 32;

    localparam logic [CFG_W-1:0]         CAPACITY_RESET = CFG_W'(8);
    localparam logic signed [WORD_W-1:0] MISS_VALUE     = -32'sd1;

    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } cmd_t;

    typedef struct packed {
        logic                     command;
        logic signed [WORD_W-1:0] key;
        logic signed [WORD_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic                     hit;
        logic signed [WORD_W-1:0] read_value;
        logic                     evicted;
        logic signed [WORD_W-1:0] evicted_key;
    } rsp_t;

    // handshake between a register stage and its downstream side
    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

endpackage

>>> hdl/lkv_if.sv
interface lkv_req_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [31:0] key;
    logic signed [31:0] value;

    modport source (output valid, output command, output key, output value, input ready);
    modport sink   (input valid, input command, input key, input value, output ready);
endinterface

interface lkv_rsp_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;

    modport source (output valid, output hit, output read_value, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input hit, input read_value, input evicted,
                    input evicted_key, output ready);
endinterface

interface lkv_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] capacity_in_use;

    modport source (output valid, output capacity_in_use, input ready);
    modport sink   (input valid, input capacity_in_use, output ready);
endinterface

>>> hdl/lru_key_value_cache.sv
// A transferred request is held in the request register; its result is captured in the
//   response register once that register can take it, and is visible to the sink from then on.
// Throughput: one request per cycle while the response sink keeps taking results; the tag
//   compare, LRU rank update and result are all combinational, between the two registers.
// Reset (rst_n, async, active low): all entries invalid, ranks and occupancy zero,
//   capacity_in_use back to 8, both channel registers empty.
module lru_key_value_cache
    import lkv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    lkv_cfg_if.sink   cfg,
    lkv_req_if.sink   req,
    lkv_rsp_if.source rsp
);

    req_t req_data;
    req_t held_req;
    hs_t  held_hs;
    logic core_fire;
    logic out_ready;
    rsp_t core_rsp;
    rsp_t rsp_data;

    // configuration writes are always taken; the user must make them arrive only while the cache is idle (unchecked)
    assign cfg.ready = 1'b1;

    assign req_data.command = req.command;
    assign req_data.key     = req.key;
    assign req_data.value   = req.value;

    // request register: hold one transfer until the core processes it
    lkv_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_data   (req_data),
        .out_hs    (held_hs),
        .out_ready (out_ready),
        .out_data  (held_req)
    );

    // process the held request whenever the response register can take the result
    assign core_fire = held_hs.valid && held_hs.ready;

    // table, lookup and LRU bookkeeping; entry state advances only on core_fire, capacity on cfg writes
    lkv_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg.valid && cfg.ready),
        .cfg_data (cfg.capacity_in_use),
        .fire     (core_fire),
        .req      (held_req),
        .rsp      (core_rsp)
    );

    // response register: holds a result until the sink takes it; the core stalls meanwhile
    lkv_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (held_hs.valid),
        .in_ready  (out_ready),
        .in_data   (core_rsp),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (rsp_data)
    );

    assign rsp.hit         = rsp_data.hit;
    assign rsp.read_value  = rsp_data.read_value;
    assign rsp.evicted     = rsp_data.evicted;
    assign rsp.evicted_key = rsp_data.evicted_key;

endmodule

>>> hdl/lkv_in_stage.sv
module lkv_in_stage
    import lkv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_data,
    output hs_t  out_hs,
    input  logic out_ready,
    output req_t out_data
);

    logic valid_reg;
    logic valid_next;
    req_t data_reg;

    // take a new transfer when empty or when the held one advances
    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

    assign out_hs.valid = valid_reg;
    assign out_hs.ready = out_ready;
    assign out_data     = data_reg;

endmodule

>>> hdl/lkv_out_stage.sv
module lkv_out_stage
    import lkv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  rsp_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output rsp_t out_data
);

    logic valid_reg;
    logic valid_next;
    rsp_t data_reg;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // hold the result until the downstream side takes it
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hdl/lkv_core.sv
module lkv_core
    import lkv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             fire,
    input  req_t             req,
    output rsp_t             rsp
);

    logic [CFG_W-1:0]         cap_reg;
    logic [CAPACITY-1:0]      valid_reg;
    logic [CAPACITY-1:0]      valid_next;
    logic [RANK_W-1:0]        rank_reg  [CAPACITY];
    logic [RANK_W-1:0]        rank_next [CAPACITY];
    logic [CNT_W-1:0]         occ_reg;
    logic [CNT_W-1:0]         occ_next;
    logic signed [WORD_W-1:0] key_mem   [CAPACITY];
    logic signed [WORD_W-1:0] data_mem  [CAPACITY];

    logic [CNT_W-1:0]  limit;
    logic              hit_found;
    logic [IDX_W-1:0]  hit_idx;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
    logic [IDX_W-1:0]  vic_idx;
    logic [RANK_W-1:0] oldest_rank;
    logic              promote_en;
    logic [IDX_W-1:0]  promote_idx;
    logic [RANK_W-1:0] promote_rank;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;

    // clamp the configured capacity into 1..CAPACITY
    always_comb
    begin
        if (cap_reg == '0)
        begin
            limit = CNT_W'(1);
        end
        else if (int'(cap_reg) > CAPACITY)
        begin
            limit = CNT_W'(CAPACITY);
        end
        else
        begin
            limit = CNT_W'(cap_reg);
        end
    end

    // parallel key compare, first free slot, least recent entry
    always_comb
    begin
        hit_found   = 1'b0;
        hit_idx     = '0;
        free_found  = 1'b0;
        free_idx    = '0;
        vic_idx     = '0;
        oldest_rank = RANK_W'(occ_reg - CNT_W'(1));
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (!hit_found && valid_reg[i] && key_mem[i] == req.key)
            begin
                hit_found = 1'b1;
                hit_idx   = IDX_W'(i);
            end
            if (!free_found && !valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
            // valid ranks are always a permutation of 0..occupancy-1
            if (valid_reg[i] && rank_reg[i] == oldest_rank)
            begin
                vic_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        valid_next  = valid_reg;
        occ_next    = occ_reg;
        rank_next   = rank_reg;
        promote_en  = 1'b0;
        promote_idx = hit_idx;
        wr_en       = 1'b0;
        wr_idx      = hit_idx;
        rsp         = '0;

        if (req.command == CMD_GET)
        begin
            if (hit_found)
            begin
                rsp.hit        = 1'b1;
                rsp.read_value = data_mem[hit_idx];
                promote_en     = 1'b1;
            end
            else
            begin
                rsp.read_value = MISS_VALUE;
            end
        end
        else if (hit_found)
        begin
            rsp.hit    = 1'b1;
            wr_en      = 1'b1;
            promote_en = 1'b1;
        end
        else if (occ_reg < limit && free_found)
        begin
            // age every stored entry, new entry becomes most recent
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (valid_reg[i])
                begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
            valid_next[free_idx] = 1'b1;
            rank_next[free_idx]  = '0;
            occ_next             = occ_reg + CNT_W'(1);
            wr_en                = 1'b1;
            wr_idx               = free_idx;
        end
        else
        begin
            rsp.evicted     = 1'b1;
            rsp.evicted_key = key_mem[vic_idx];
            wr_en           = 1'b1;
            wr_idx          = vic_idx;
            promote_en      = 1'b1;
            promote_idx     = vic_idx;
        end

        promote_rank = rank_reg[promote_idx];
        if (promote_en)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (valid_reg[i] && IDX_W'(i) != promote_idx && rank_reg[i] < promote_rank)
                begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
            rank_next[promote_idx] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAPACITY_RESET;
            valid_reg <= '0;
            occ_reg   <= '0;
            for (int i = 0; i < CAPACITY; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (fire)
            begin
                valid_reg <= valid_next;
                occ_reg   <= occ_next;
                rank_reg  <= rank_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && wr_en)
        begin
            key_mem[wr_idx]  <= req.key;
            data_mem[wr_idx] <= req.value;
        end
    end

endmodule

>>> hdl/lkv_checker.sv
module lkv_checker
    import lkv_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic               hit,
    input logic signed [31:0] read_value,
    input logic               evicted,
    input logic signed [31:0] evicted_key
);

    // a stalled response holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(hit) && $stable(read_value)
            && $stable(evicted) && $stable(evicted_key))
        else $error("response changed while stalled");

    // an eviction only comes from a put of a new key
    a_evict_put: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && evicted |-> !hit && read_value == 32'sd0)
        else $error("eviction reported with a hit or a read value");

    a_evict_key: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !evicted |-> evicted_key == 32'sd0)
        else $error("evicted key set without an eviction");

    // a response appearing from empty follows a request transfer through the request and response registers
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("response without a matching request");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .hit         (rsp.hit),
    .read_value  (rsp.read_value),
    .evicted     (rsp.evicted),
    .evicted_key (rsp.evicted_key)
);

>>> test/lru_key_value_cache_tb.sv
`timescale 1ns / 1ps

module lru_key_value_cache_tb
    import lkv_pkg::*;
();

    // ------------------------------------------------------------------
    // Run constants
    // ------------------------------------------------------------------
    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 4;
    localparam int IDLE_LIMIT    = 1000;  // cycles without any transfer before giving up
    localparam int MAX_GAP       = 10;
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 146;
    localparam int POOL_SIZE     = 10;
    localparam int PLAN_LEN      = 25;

    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
    localparam rsp_t NO_WANT = '0;

    // Directed rows are either a request or a capacity write (capacity in value).
    typedef enum logic {
        ROW_REQ = 1'b0,
        ROW_CFG = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        cmd_t                     cmd;
        logic signed [WORD_W-1:0] key;
        logic signed [WORD_W-1:0] value;
        logic                     has_want;  // expected reply typed into the row
        rsp_t                     want;
    } stim_row_t;

    // ------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always #CLK_HALF clk = ~clk;

    lkv_req_if req_if ();
    lkv_rsp_if rsp_if ();
    lkv_cfg_if cfg_if ();

    lru_key_value_cache dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // ------------------------------------------------------------------
    // Cache shadow: keys, data, occupancy and recency ranks as the block
    // should hold them, plus the capacity register as last written.
    // ------------------------------------------------------------------
    logic signed [WORD_W-1:0] slot_key  [CAPACITY];
    logic signed [WORD_W-1:0] slot_data [CAPACITY];
    bit                       slot_used [CAPACITY];
    int                       slot_rank [CAPACITY];
    int                       occupied;
    logic [CFG_W-1:0]         capacity_setting;

    // Replies still owed by the block, oldest first
    rsp_t expected_replies [$];

    int  mismatch_count;
    int  get_count, put_count, hit_count, evict_count, cfg_count;
    int  idle_cycles;
    bit  no_idle;        // burst phases: neither side inserts gaps
    int  rsp_hold;       // cycles the response side still holds ready low

    // Directed table: extremes of key and value, both commands, hit and miss,
    // update in place, fill to the top, eviction, capacity lowered below the
    // current occupancy, capacity zero and capacity above the table size.
    stim_row_t plan [PLAN_LEN] = '{
        '{ROW_REQ, CMD_GET, 32'sd0,   32'sd0,   1'b1, '{1'b0, MISS_VALUE, 1'b0, 32'sd0}},
        '{ROW_REQ, CMD_GET, WORD_MIN, 32'sd0,   1'b1, '{1'b0, MISS_VALUE, 1'b0, 32'sd0}},
        '{ROW_REQ, CMD_PUT, WORD_MIN, WORD_MAX, 1'b1, '{1'b0, 32'sd0, 1'b0, 32'sd0}},
        '{ROW_REQ, CMD_PUT, WORD_MAX, WORD_MIN, 1'b1, '{1'b0, 32'sd0, 1'b0, 32'sd0}},
        '{ROW_REQ, CMD_GET, WORD_MIN, WORD_MIN, 1'b1, '{1'b1, WORD_MAX, 1'b0, 32'sd0}},
        '{ROW_REQ, CMD_GET, WORD_MAX, WORD_MAX, 1'b1, '{1'b1, WORD_MIN, 1'b0, 32'sd0}},
        '{ROW_REQ, CMD_PUT, WORD_MAX, 32'sd0,   1'b1, '{1'b1, 32'sd0, 1'b0, 32'sd0}},
        '{ROW_REQ, CMD_PUT, 32'sd1,   -32'sd11, 1'b0, NO_WANT},
        '{ROW_REQ, CMD_PUT, 32'sd2,   -32'sd12, 1'b0, NO_WANT},
        '{ROW_REQ, CMD_PUT, 32'sd3,   -32'sd13, 1'b0, NO_WANT},
        '{ROW_REQ, CMD_PUT, 32'sd4,   -32'sd14, 1'b0, NO_WANT},
        '{ROW_REQ, CMD_PUT, 32'sd5,   -32'sd15, 1'b0, NO_WANT},
        '{ROW_REQ, CMD_PUT, 32'sd6,   -32'sd16, 1'b0, NO_WANT},
        '{ROW_REQ, CMD_PUT, -32'sd1,  32'sh5a5a_5a5a, 1'b0, NO_WANT},
        '{ROW_REQ, CMD_GET, 32'sd3,   32'sd0,   1'b0, NO_WANT},
        '{ROW_CFG, CMD_GET, 32'sd0,   32'sd2,   1'b0, NO_WANT},
        '{ROW_REQ, CMD_PUT, 32'sd100, 32'sd1,   1'b0, NO_WANT},
        '{ROW_REQ, CMD_GET, WORD_MIN, 32'sd0,   1'b0, NO_WANT},
        '{ROW_CFG, CMD_GET, 32'sd0,   32'sd0,   1'b0, NO_WANT},
        '{ROW_REQ, CMD_PUT, 32'sd200, 32'sd2,   1'b0, NO_WANT},
        '{ROW_REQ, CMD_GET, 32'sd200, 32'sd0,   1'b0, NO_WANT},
        '{ROW_CFG, CMD_GET, 32'sd0,   32'sd15,  1'b0, NO_WANT},
        '{ROW_REQ, CMD_PUT, 32'sd300, WORD_MIN, 1'b0, NO_WANT},
        '{ROW_REQ, CMD_GET, -32'sd1,  32'sd0,   1'b0, NO_WANT},
        '{ROW_CFG, CMD_GET, 32'sd0,   32'sd8,   1'b0, NO_WANT}
    };

    // ------------------------------------------------------------------
    // Shadow cache update
    // ------------------------------------------------------------------

    // Make entry e the most recent; every valid entry newer than it ages by one.
    function automatic void promote_entry(int e);
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (slot_used[i] && i != e && slot_rank[i] < slot_rank[e])
                slot_rank[i]++;
        end
        slot_rank[e] = 0;
    endfunction

    // Work out the reply to one request and advance the shadow cache.
    function automatic rsp_t predict_access(req_t r);
        rsp_t o;
        int   e;
        int   limit;
        int   slot;
        int   victim;
        o      = '0;
        e      = -1;
        slot   = -1;
        victim = -1;
        // capacity zero acts as one, anything past the table as the table size
        limit = int'(capacity_setting);
        if (limit < 1)
            limit = 1;
        if (limit > CAPACITY)
            limit = CAPACITY;

        for (int i = 0; i < CAPACITY; i++)
        begin
            if (e < 0 && slot_used[i] && slot_key[i] == r.key)
                e = i;
        end

        if (r.command == CMD_GET)
        begin
            if (e >= 0)
            begin
                o.hit        = 1'b1;
                o.read_value = slot_data[e];
                promote_entry(e);
            end
            else
                o.read_value = MISS_VALUE;   // miss leaves the cache alone
        end
        else if (e >= 0)
        begin
            o.hit        = 1'b1;
            slot_data[e] = r.value;
            promote_entry(e);
        end
        else
        begin
            // new key: lowest free slot while below capacity, else replace the LRU
            if (occupied < limit)
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (slot < 0 && !slot_used[i])
                        slot = i;
                end
            end
            if (slot >= 0)
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (slot_used[i])
                        slot_rank[i]++;
                end
                slot_used[slot] = 1'b1;
                slot_key[slot]  = r.key;
                slot_data[slot] = r.value;
                slot_rank[slot] = 0;
                occupied++;
            end
            else
            begin
                // occupancy is left as is, even when capacity dropped below it
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (slot_used[i] && (victim < 0 || slot_rank[i] > slot_rank[victim]))
                        victim = i;
                end
                if (victim >= 0)
                begin
                    o.evicted         = 1'b1;
                    o.evicted_key     = slot_key[victim];
                    slot_key[victim]  = r.key;
                    slot_data[victim] = r.value;
                    promote_entry(victim);
                end
            end
        end
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Idle for gap cycles, then offer one request and hold it until transferred.
    // With gap zero valid simply stays high into the next request.
    task automatic issue(input cmd_t c, input logic signed [WORD_W-1:0] k,
                         input logic signed [WORD_W-1:0] v, input logic has_want,
                         input rsp_t want, input int gap);
        req_t r;
        rsp_t guess;
        repeat (gap)
        begin
            @(negedge clk);
            req_if.valid <= 1'b0;
        end
        @(negedge clk);
        req_if.valid   <= 1'b1;
        req_if.command <= c;
        req_if.key     <= k;
        req_if.value   <= v;
        do
            @(posedge clk);
        while (!req_if.ready);

        r.command = c;
        r.key     = k;
        r.value   = v;
        guess = predict_access(r);   // always run, so the shadow keeps in step
        expected_replies.push_back(has_want ? want : guess);
        if (c == CMD_GET)
            get_count++;
        else
            put_count++;
        if (guess.hit)
            hit_count++;
        if (guess.evicted)
            evict_count++;
    endtask

    // Drop valid and wait until every owed reply is in and the pipe is empty.
    task automatic drain();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Capacity writes only happen with the block idle.
    task automatic write_capacity(input logic [CFG_W-1:0] c);
        drain();
        @(negedge clk);
        cfg_if.valid           <= 1'b1;
        cfg_if.capacity_in_use <= c;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        capacity_setting = c;
        cfg_count++;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic signed [WORD_W-1:0] draw_value();
        case ($urandom_range(0, 9))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Response side: hold ready low for a drawn number of cycles per reply
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else if (rsp_hold > 0)
        begin
            rsp_if.ready <= 1'b0;
            rsp_hold     <= rsp_hold - 1;
        end
        else
            rsp_if.ready <= 1'b1;
    end

    // Check each transferred reply against the oldest owed one, field by field.
    always @(posedge clk)
    begin : reply_check
        rsp_t got;
        rsp_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got.hit         = rsp_if.hit;
            got.read_value  = rsp_if.read_value;
            got.evicted     = rsp_if.evicted;
            got.evicted_key = rsp_if.evicted_key;
            if (expected_replies.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: reply with none owed: hit=%0b read=%0d evicted=%0b key=%0d",
                             $time, got.hit, got.read_value, got.evicted, got.evicted_key);
            end
            else
            begin
                want = expected_replies.pop_front();
                if (got.hit !== want.hit || got.read_value !== want.read_value ||
                    got.evicted !== want.evicted || got.evicted_key !== want.evicted_key)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: mismatch hit %0b/%0b read %0d/%0d evicted %0b/%0b key %0d/%0d (expected/actual)",
                                 $time, want.hit, got.hit, want.read_value, got.read_value,
                                 want.evicted, got.evicted, want.evicted_key, got.evicted_key);
                end
            end
            rsp_hold <= no_idle ? 0 : $urandom_range(0, MAX_GAP);
        end
    end

    // Watchdog: too long without a transfer on any channel ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles, %0d replies owed",
                         idle_cycles, expected_replies.size());
                $display("CHECKS FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic signed [WORD_W-1:0] key_pool [POOL_SIZE];
        logic signed [WORD_W-1:0] k;
        logic [CFG_W-1:0]         cap;
        int                       gap;

        // known levels on every input from time zero
        rst_n                  = 1'b0;
        req_if.valid           = 1'b0;
        req_if.command         = CMD_GET;
        req_if.key             = '0;
        req_if.value           = '0;
        cfg_if.valid           = 1'b0;
        cfg_if.capacity_in_use = '0;
        rsp_if.ready           = 1'b0;
        rsp_hold               = 0;
        no_idle                = 1'b0;
        idle_cycles            = 0;
        mismatch_count         = 0;
        get_count              = 0;
        put_count              = 0;
        hit_count              = 0;
        evict_count            = 0;
        cfg_count              = 0;

        // shadow cache starts as the block does out of reset
        for (int i = 0; i < CAPACITY; i++)
        begin
            slot_used[i] = 1'b0;
            slot_rank[i] = 0;
            slot_key[i]  = '0;
            slot_data[i] = '0;
        end
        occupied         = 0;
        capacity_setting = CAPACITY_RESET;

        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (plan[i].kind == ROW_CFG)
                write_capacity(plan[i].value[CFG_W-1:0]);
            else
                issue(plan[i].cmd, plan[i].key, plan[i].value, plan[i].has_want,
                      plan[i].want, $urandom_range(0, MAX_GAP));
        end

        // random phases, each under its own capacity; the first few pin the extremes
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       cap = 4'd1;
                1:       cap = 4'd8;
                2:       cap = 4'd0;
                3:       cap = 4'd15;
                4:       cap = 4'd3;
                default: cap = 4'($urandom_range(0, 15));
            endcase
            write_capacity(cap);
            no_idle = (p % 3 == 1);   // every third phase runs back to back

            // small key pool per phase so hits, updates and evictions are common
            key_pool[0] = WORD_MIN;
            key_pool[1] = WORD_MAX;
            key_pool[2] = '0;
            key_pool[3] = -32'sd1;
            for (int j = 4; j < POOL_SIZE; j++)
                key_pool[j] = $urandom;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 3) != 0)
                    k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                else
                    k = $urandom;
                gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
                issue(cmd_t'($urandom_range(0, 1)), k, draw_value(), 1'b0, NO_WANT, gap);
            end
        end

        drain();

        $display("Covered %0d requests (%0d gets, %0d puts) with %0d hits and %0d evictions.",
                 get_count + put_count, get_count, put_count, hit_count, evict_count);
        $display("Capacity written %0d times (0, 1, 3, 8, 15 and random); %0d mismatches.",
                 cfg_count, mismatch_count);
        if (mismatch_count == 0 && expected_replies.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> lru_key_value_cache.f
hdl/lkv_pkg.sv
hdl/lkv_if.sv
hdl/lkv_in_stage.sv
hdl/lkv_out_stage.sv
hdl/lkv_core.sv
hdl/lru_key_value_cache.sv
hdl/lkv_checker.sv
test/lru_key_value_cache_tb.sv
